// ----- src/elph_pkg.sv -----
// shared types and constants of the edge list partition histogram
// no dependencies; every other file of the block but elph_ram imports or uses this package
`default_nettype none

package elph_pkg;

  // field widths of the request and result channels
  localparam int FUNC_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int PART_W  = 9;
  localparam int COUNT_W = 32;

  // partition index width that covers the largest supported partition count
  localparam int IDX_W = 10;

  // result queue between the table pipeline and the output channel
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // request function codes
  localparam logic [FUNC_W-1:0] FN_TEXT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_READ = 2'd1;
  localparam logic [FUNC_W-1:0] FN_END  = 2'd2;

  // table operation carried by each request through the pipeline
  typedef enum logic [1:0] {
    OP_ZERO  = 2'd0,
    OP_COUNT = 2'd1,
    OP_READ  = 2'd2
  } elph_op_t;

  typedef struct packed {
    elph_op_t         op;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic             err;
  } elph_ev_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               err;
  } elph_res_t;

  typedef struct packed {
    logic       busy;
    logic [1:0] inflight;
  } elph_stat_t;

endpackage

`default_nettype wire

// ----- src/elph_in_if.sv -----
// request channel of the edge list partition histogram
// depends on elph_pkg for the field widths
`default_nettype none

interface elph_in_if;
  import elph_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] text_byte;
  logic [PART_W-1:0] row;
  logic [PART_W-1:0] col;

  modport source (output valid, output func, output text_byte, output row, output col,
                  input ready);
  modport sink (input valid, input func, input text_byte, input row, input col,
                output ready);
endinterface

`default_nettype wire

// ----- src/elph_out_if.sv -----
// result channel of the edge list partition histogram
// depends on elph_pkg for the field widths
`default_nettype none

interface elph_out_if;
  import elph_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] count_value;
  logic               parse_error;

  modport source (output valid, output count_value, output parse_error, input ready);
  modport sink (input valid, input count_value, input parse_error, output ready);
endinterface

`default_nettype wire

// ----- src/elph_ram.sv -----
// generic simple dual port ram, one write and one registered read port
// no dependencies; a read of the address being written returns the old data
`default_nettype none

module elph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/elph_parse.sv -----
// edge list text parser: token state machine and residue unit
// depends on elph_pkg; emits one table event per accepted request
`default_nettype none

module elph_parse #(
  parameter int PARTS = 320
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          accept,
  input  wire  [elph_pkg::FUNC_W-1:0]  func,
  input  wire  [elph_pkg::BYTE_W-1:0]  text_byte,
  input  wire  [elph_pkg::PART_W-1:0]  row,
  input  wire  [elph_pkg::PART_W-1:0]  col,
  output logic                         ev_valid,
  output elph_pkg::elph_ev_t           ev
);
  import elph_pkg::*;

  localparam int RW = $clog2(PARTS);
  localparam logic [RW:0] P_W = (RW+1)'(PARTS);

  typedef enum logic [4:0] {
    PH_START   = 5'b00001,
    PH_COMMENT = 5'b00010,
    PH_SOURCE  = 5'b00100,
    PH_DEST    = 5'b01000,
    PH_TRAIL   = 5'b10000
  } elph_phase_t;

  elph_phase_t   phase_r, phase_nxt;
  logic [RW-1:0] src_r, src_nxt;
  logic [RW-1:0] dst_r, dst_nxt;
  logic          ds_r, ds_nxt;
  logic          err_r, err_nxt;

  logic          is_blank, is_white, is_digit, is_hash, is_eol;
  logic [RW-1:0] r_in, r2, r4, r8, r10, r_new;

  // doubling modulo PARTS for a value already below PARTS
  function automatic logic [RW-1:0] mod_dbl(input logic [RW-1:0] x);
    logic [RW:0] y;
    y = {x, 1'b0};
    if (y >= P_W) y = y - P_W;
    return y[RW-1:0];
  endfunction

  // sum modulo PARTS of two values below PARTS
  function automatic logic [RW-1:0] mod_add(input logic [RW-1:0] x, input logic [RW-1:0] z);
    logic [RW:0] y;
    y = {1'b0, x} + {1'b0, z};
    if (y >= P_W) y = y - P_W;
    return y[RW-1:0];
  endfunction

  // digit value modulo PARTS
  function automatic logic [RW-1:0] dig_mod(input logic [3:0] d);
    logic [RW-1:0] m;
    case (d)
      4'd0:    m = RW'(0 % PARTS);
      4'd1:    m = RW'(1 % PARTS);
      4'd2:    m = RW'(2 % PARTS);
      4'd3:    m = RW'(3 % PARTS);
      4'd4:    m = RW'(4 % PARTS);
      4'd5:    m = RW'(5 % PARTS);
      4'd6:    m = RW'(6 % PARTS);
      4'd7:    m = RW'(7 % PARTS);
      4'd8:    m = RW'(8 % PARTS);
      4'd9:    m = RW'(9 % PARTS);
      default: m = '0;
    endcase
    return m;
  endfunction

  // character classes
  assign is_blank = text_byte inside {8'h20, 8'h09};
  assign is_white = text_byte inside {8'h20, [8'h09:8'h0D]};
  assign is_digit = text_byte inside {[8'h30:8'h39]};
  assign is_hash  = (text_byte == 8'h23);
  assign is_eol   = text_byte inside {8'h0A, 8'h0D};

  // residue unit: r = (10*r + d) mod PARTS as doublings and adds
  assign r_in  = (ds_r && (phase_r != PH_START)) ? ((phase_r == PH_DEST) ? dst_r : src_r)
                                                 : '0;
  assign r2    = mod_dbl(r_in);
  assign r4    = mod_dbl(r2);
  assign r8    = mod_dbl(r4);
  assign r10   = mod_add(r8, r2);
  assign r_new = mod_add(r10, dig_mod(text_byte[3:0]));

  // token state machine and event generation
  always_comb begin
    phase_nxt = phase_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    ds_nxt    = ds_r;
    err_nxt   = err_r;
    ev.op     = OP_ZERO;
    ev.a      = '0;
    ev.b      = '0;
    ev.err    = err_r;
    if (accept) begin
      case (func)
        FN_TEXT: begin
          if (!err_r) begin
            case (phase_r)
              PH_START: begin
                if (is_hash) begin
                  phase_nxt = PH_COMMENT;
                end else if (!is_blank) begin
                  // the byte opens the source number
                  phase_nxt = PH_SOURCE;
                  ds_nxt    = 1'b0;
                  if (is_digit) begin
                    src_nxt = r_new;
                    ds_nxt  = 1'b1;
                  end else if (!is_white) begin
                    err_nxt = 1'b1;
                  end
                end
              end
              PH_COMMENT: begin
                if (is_eol) begin
                  phase_nxt = PH_SOURCE;
                  ds_nxt    = 1'b0;
                end
              end
              PH_SOURCE: begin
                if (is_digit) begin
                  src_nxt = r_new;
                  ds_nxt  = 1'b1;
                end else if (ds_r) begin
                  // source done, byte is looked at again as a destination lead
                  phase_nxt = PH_DEST;
                  ds_nxt    = 1'b0;
                  if (!is_white) err_nxt = 1'b1;
                end else if (!is_white) begin
                  err_nxt = 1'b1;
                end
              end
              PH_DEST: begin
                if (is_digit) begin
                  dst_nxt = r_new;
                  ds_nxt  = 1'b1;
                end else if (ds_r) begin
                  // pair complete; a non-blank ending byte is discarded at once
                  ev.op     = OP_COUNT;
                  ev.a      = IDX_W'(src_r);
                  ev.b      = IDX_W'(dst_r);
                  ds_nxt    = 1'b0;
                  phase_nxt = is_blank ? PH_TRAIL : PH_START;
                end else if (!is_white) begin
                  err_nxt = 1'b1;
                end
              end
              PH_TRAIL: begin
                if (!is_blank) begin
                  phase_nxt = PH_START;
                  ds_nxt    = 1'b0;
                end
              end
              default: begin
                phase_nxt = PH_START;
              end
            endcase
          end
          ev.err = err_nxt;
        end
        FN_READ: begin
          if ((32'(row) < 32'(PARTS)) && (32'(col) < 32'(PARTS))) begin
            ev.op = OP_READ;
            ev.a  = IDX_W'(row);
            ev.b  = IDX_W'(col);
          end
        end
        FN_END: begin
          // a pending destination with digits is counted, then the text restarts
          if (!err_r && (phase_r == PH_DEST) && ds_r) begin
            ev.op = OP_COUNT;
            ev.a  = IDX_W'(src_r);
            ev.b  = IDX_W'(dst_r);
          end
          phase_nxt = PH_START;
          src_nxt   = '0;
          dst_nxt   = '0;
          ds_nxt    = 1'b0;
          err_nxt   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign ev_valid = accept;

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      src_r   <= '0;
      dst_r   <= '0;
      ds_r    <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      ds_r    <= ds_nxt;
      err_r   <= err_nxt;
    end
  end

  // end of text always returns to a clean record start
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (func == FN_END) |=> (phase_r == PH_START) && !err_r && !ds_r)
    else $error("end of text did not restart the parser");

  // an error sticks until end of text
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r && !(accept && (func == FN_END)) |=> err_r)
    else $error("parse error cleared before end of text");

  // counted pairs always address inside the table
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    ev_valid && (ev.op == OP_COUNT) |-> (32'(ev.a) < 32'(PARTS)) && (32'(ev.b) < 32'(PARTS)))
    else $error("count event outside the partition range");

endmodule

`default_nettype wire

// ----- src/elph_table.sv -----
// counter table: address stage, ram read, saturating increment with forwarding
// depends on elph_pkg and elph_ram; clears the whole ram after reset
`default_nettype none

module elph_table #(
  parameter int PARTS = 320
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      ev_valid,
  input  wire elph_pkg::elph_ev_t  ev,
  output logic                     res_valid,
  output elph_pkg::elph_res_t      res,
  output elph_pkg::elph_stat_t     stat
);
  import elph_pkg::*;

  localparam int DEPTH = PARTS * PARTS;
  localparam int AW    = $clog2(DEPTH);

  logic               s1_valid_r;
  elph_ev_t           s1_ev_r;
  logic               s2_valid_r;
  elph_op_t           s2_op_r;
  logic               s2_err_r;
  logic [AW-1:0]      s2_addr_r;
  logic               s3_valid_r;
  elph_op_t           s3_op_r;
  logic               s3_err_r;
  logic [AW-1:0]      s3_addr_r;
  logic               lw_valid_r;
  logic [AW-1:0]      lw_addr_r;
  logic [COUNT_W-1:0] lw_data_r;
  logic               clr_busy_r;
  logic [AW-1:0]      clr_addr_r;

  logic [AW-1:0]      addr_nxt;
  logic               s3_count;
  logic [COUNT_W-1:0] rdata, cur, inc_val;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [COUNT_W-1:0] wdata;

  // stage 1: row-major address
  assign addr_nxt = AW'(32'(s1_ev_r.a) * PARTS + 32'(s1_ev_r.b));

  // stage 3: forward the previous cycle's write over the ram data
  assign s3_count = s3_valid_r && (s3_op_r == OP_COUNT);
  assign cur      = (lw_valid_r && (lw_addr_r == s3_addr_r)) ? lw_data_r : rdata;
  assign inc_val  = (cur == COUNT_MAX) ? cur : cur + COUNT_W'(1);

  // write port shared by the clearing pass and the increments
  assign we    = clr_busy_r || s3_count;
  assign waddr = clr_busy_r ? clr_addr_r : s3_addr_r;
  assign wdata = clr_busy_r ? '0 : inc_val;

  elph_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (s2_addr_r),
    .rdata (rdata)
  );

  // pipeline valid bits, forwarding record and clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      lw_valid_r <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      s1_valid_r <= ev_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      lw_valid_r <= s3_count;
      if (clr_busy_r) begin
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_ev_r   <= ev;
    s2_op_r   <= s1_ev_r.op;
    s2_err_r  <= s1_ev_r.err;
    s2_addr_r <= addr_nxt;
    s3_op_r   <= s2_op_r;
    s3_err_r  <= s2_err_r;
    s3_addr_r <= s2_addr_r;
    lw_addr_r <= s3_addr_r;
    lw_data_r <= inc_val;
  end

  // result and status
  assign res_valid     = s3_valid_r;
  assign res.count     = (s3_op_r == OP_READ) ? cur : '0;
  assign res.err       = s3_err_r;
  assign stat.busy     = clr_busy_r;
  assign stat.inflight = {1'b0, s1_valid_r} + {1'b0, s2_valid_r} + {1'b0, s3_valid_r};

  // no request enters while the table is being cleared
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !ev_valid && !s3_valid_r)
    else $error("request entered the table during the clearing pass");

  // the clearing pass ends only after the last entry
  a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy_r) |-> $past(clr_addr_r) == AW'(DEPTH - 1))
    else $error("clearing pass ended early");

  // an increment never lowers a counter
  a_inc_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    s3_count && !clr_busy_r |-> (inc_val >= cur) && (inc_val != '0))
    else $error("counter increment wrapped or decreased");

endmodule

`default_nettype wire

// ----- src/edge_list_partition_histogram_top.sv -----
// top level of the edge list partition histogram: parser, counter table, result queue
// depends on elph_pkg, elph_in_if, elph_out_if, elph_parse, elph_table and elph_ram
`default_nettype none

// Takes an edge-list text one byte per request (func 0), counter queries (func 1)
// and end of text (func 2), and returns one result per request in order.
// Sustained rate is one request per cycle while results are taken, including runs of
// increments to the same counter, since the table is a read-modify-write pipeline
// that forwards the last write back over the ram read data. A request passes
// through the address multiply, ram read, increment and write back, and the result
// queue. in_ready drops when the results waiting in the queue plus those in the
// three table stages reach the eight queue entries.
// After reset the counter ram is cleared one entry per cycle, all PARTS*PARTS entries
// (102400 at the default of 320), and in_ready stays low during that pass.

module edge_list_partition_histogram_top #(
  parameter int PARTS = 320
) (
  input wire         clk,
  input wire         rst_n,
  elph_in_if.sink    in_ch,
  elph_out_if.source out_ch
);
  import elph_pkg::*;

  logic       accept;
  logic       ev_valid;
  elph_ev_t   ev;
  logic       res_valid;
  elph_res_t  res;
  elph_stat_t stat;

  elph_res_t          fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   occ_r, occ_nxt;
  logic               push, pop;

  // request handshake: room for everything already in flight
  assign in_ch.ready = !stat.busy &&
                       ((5'(occ_r) + 5'(stat.inflight)) < 5'(FIFO_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;

  elph_parse #(
    .PARTS (PARTS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .func      (in_ch.func),
    .text_byte (in_ch.text_byte),
    .row       (in_ch.row),
    .col       (in_ch.col),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  elph_table #(
    .PARTS (PARTS)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (ev_valid),
    .ev        (ev),
    .res_valid (res_valid),
    .res       (res),
    .stat      (stat)
  );

  // result queue
  assign push    = res_valid;
  assign pop     = out_ch.valid && out_ch.ready;
  assign occ_nxt = occ_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      occ_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= res;
    end
  end

  assign out_ch.valid       = (occ_r != '0);
  assign out_ch.count_value = fifo_r[rd_ptr_r].count;
  assign out_ch.parse_error = fifo_r[rd_ptr_r].err;

  // queue never holds more than its depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue occupancy above depth");

  // a result never arrives at a full queue that is not draining
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> occ_r != (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  // queued plus in-flight results always fit
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (5'(occ_r) + 5'(stat.inflight)) <= 5'(FIFO_DEPTH))
    else $error("more results in flight than queue space");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// self-checking testbench of the edge list partition histogram
// depends on elph_pkg, elph_in_if, elph_out_if and edge_list_partition_histogram_top
`timescale 1ns / 100ps
`default_nettype none

module testbench;
  import elph_pkg::*;

  localparam int PARTS        = 320;
  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE       = 8;

  // selector value that the block leaves unused
  localparam logic [FUNC_W-1:0] FN_NONE = 2'd3;

  // characters the parser cares about
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    REC_START,
    IN_COMMENT,
    IN_SOURCE,
    IN_DEST,
    IN_TRAIL
  } scan_phase_t;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] text_byte;
    logic [PART_W-1:0] row;
    logic [PART_W-1:0] col;
    bit                typed;
    elph_res_t         want;
  } steer_row_t;

  logic clk;
  logic rst_n;

  elph_in_if  in_ch();
  elph_out_if out_ch();

  edge_list_partition_histogram_top #(
    .PARTS(PARTS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // parser and counter table as the block should hold them
  scan_phase_t       scan_phase = REC_START;
  int unsigned       src_res    = 0;
  int unsigned       dst_res    = 0;
  bit                have_digit = 1'b0;
  bit                bad_text   = 1'b0;
  bit [COUNT_W-1:0]  pair_tally [PARTS*PARTS];
  int unsigned       hit_cells [$];

  elph_res_t  expect_q [$];
  steer_row_t steer_rows [$];

  bit quiet = 1'b0;
  int fails = 0;
  int cycle_count = 0;
  int req_total = 0;
  int useful_items = 0;
  int results_checked = 0;
  int pairs_counted = 0;
  int error_texts = 0;

  function automatic bit is_blank(logic [BYTE_W-1:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic bit is_white(logic [BYTE_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_digit(logic [BYTE_W-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic int unsigned fold_digit(int unsigned r, logic [BYTE_W-1:0] c);
    return (r * 10 + (int'(c) - int'(CH_ZERO))) % PARTS;
  endfunction

  // saturating increment of the current pair
  function automatic void bump_pair();
    int unsigned idx;
    idx = src_res * PARTS + dst_res;
    if (pair_tally[idx] != COUNT_MAX) pair_tally[idx]++;
    hit_cells.push_back(idx);
    pairs_counted++;
  endfunction

  // one text byte through the parser, with re-scan of a number's terminator
  function automatic void scan_byte(logic [BYTE_W-1:0] c);
    bit again;
    again = 1'b1;
    while (again && !bad_text) begin
      again = 1'b0;
      case (scan_phase)
        REC_START: begin
          if (!is_blank(c)) begin
            if (c == CH_HASH) begin
              scan_phase = IN_COMMENT;
            end else begin
              scan_phase = IN_SOURCE;
              have_digit = 1'b0;
              again = 1'b1;
            end
          end
        end
        IN_COMMENT: begin
          if (c == CH_LF || c == CH_CR) begin
            scan_phase = IN_SOURCE;
            have_digit = 1'b0;
          end
        end
        IN_SOURCE: begin
          if (is_digit(c)) begin
            src_res = fold_digit(have_digit ? src_res : 0, c);
            have_digit = 1'b1;
          end else if (have_digit) begin
            scan_phase = IN_DEST;
            have_digit = 1'b0;
            again = 1'b1;
          end else if (!is_white(c)) begin
            bad_text = 1'b1;
          end
        end
        IN_DEST: begin
          if (is_digit(c)) begin
            dst_res = fold_digit(have_digit ? dst_res : 0, c);
            have_digit = 1'b1;
          end else if (have_digit) begin
            bump_pair();
            scan_phase = IN_TRAIL;
            have_digit = 1'b0;
            again = 1'b1;
          end else if (!is_white(c)) begin
            bad_text = 1'b1;
          end
        end
        default: begin
          // trailing blanks, then one character dropped
          if (!is_blank(c)) begin
            scan_phase = REC_START;
            have_digit = 1'b0;
          end
        end
      endcase
    end
  endfunction

  // expected result of one request, advancing the parser state
  function automatic elph_res_t histogram_step(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] b,
                                               logic [PART_W-1:0] r, logic [PART_W-1:0] c);
    elph_res_t res;
    res = '0;
    case (f)
      FN_TEXT: begin
        scan_byte(b);
        res.err = bad_text;
      end
      FN_READ: begin
        if (r < PARTS && c < PARTS) res.count = pair_tally[r * PARTS + c];
        res.err = bad_text;
      end
      FN_END: begin
        if (!bad_text && scan_phase == IN_DEST && have_digit) bump_pair();
        res.err = bad_text;
        if (bad_text) error_texts++;
        scan_phase = REC_START;
        src_res = 0;
        dst_res = 0;
        have_digit = 1'b0;
        bad_text = 1'b0;
      end
      default: res.err = bad_text;
    endcase
    return res;
  endfunction

  // one request: random hold-off, drive, wait for the handshake, predict
  task automatic send_req(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] b,
                          input logic [PART_W-1:0] r, input logic [PART_W-1:0] c,
                          input bit typed = 1'b0, input elph_res_t typed_res = '0);
    elph_res_t predicted;
    bit ignored;
    ignored = (f == FN_TEXT) && bad_text;
    while (!quiet && $urandom_range(99) < 7) begin
      in_ch.valid     <= 1'b0;
      in_ch.func      <= FUNC_W'($urandom_range(3));
      in_ch.text_byte <= BYTE_W'($urandom_range(255));
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.text_byte <= b;
    in_ch.row       <= r;
    in_ch.col       <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = histogram_step(f, b, r, c);
    expect_q.push_back(typed ? typed_res : predicted);
    req_total++;
    if (!ignored) useful_items++;
  endtask

  task automatic send_text(input logic [BYTE_W-1:0] c);
    send_req(FN_TEXT, c, PART_W'($urandom_range(511)), PART_W'($urandom_range(511)));
  endtask

  function automatic logic [BYTE_W-1:0] pick_blank();
    return ($urandom_range(2) == 0) ? CH_TAB : CH_SPACE;
  endfunction

  // any white space, line ends included
  function automatic logic [BYTE_W-1:0] pick_white();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return CH_SPACE;
      5, 6:          return CH_TAB;
      7:             return CH_LF;
      8:             return CH_CR;
      default:       return $urandom_range(1) ? CH_VT : CH_FF;
    endcase
  endfunction

  // character that closes a record and is dropped
  function automatic logic [BYTE_W-1:0] pick_end();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return CH_LF;
      6, 7:             return CH_CR;
      8:                return BYTE_W'($urandom_range(8'h21, 8'h7E));
      default:          return BYTE_W'($urandom_range(255));
    endcase
  endfunction

  // decimal number: mostly one digit so counters repeat, sometimes long ones
  task automatic send_number();
    string digits;
    longint unsigned v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: digits = $sformatf("%0d", $urandom_range(9));
      6, 7: begin
        digits = "";
        repeat ($urandom_range(2, 7)) digits = {digits, $sformatf("%0d", $urandom_range(9))};
      end
      8: begin
        // residues at the ends of the partition range
        v = longint'($urandom_range(3000)) * PARTS + ($urandom_range(1) ? PARTS - 1 : 0);
        digits = $sformatf("%0d", v);
      end
      default: begin
        v = {$urandom, $urandom};
        digits = $sformatf("%0d", v);
      end
    endcase
    for (int i = 0; i < digits.len(); i++) send_text(digits[i]);
  endtask

  task automatic send_comment();
    logic [BYTE_W-1:0] c;
    send_text(CH_HASH);
    repeat ($urandom_range(6)) begin
      c = BYTE_W'($urandom_range(255));
      if (c == CH_LF || c == CH_CR) c = CH_SPACE;
      send_text(c);
    end
    send_text($urandom_range(1) ? CH_LF : CH_CR);
  endtask

  // counter read: mostly a cell that has been counted
  task automatic send_query();
    int unsigned idx;
    if (hit_cells.size() != 0 && $urandom_range(9) < 7) begin
      idx = hit_cells[$urandom_range(hit_cells.size() - 1)];
      send_req(FN_READ, BYTE_W'($urandom_range(255)), PART_W'(idx / PARTS),
               PART_W'(idx % PARTS));
    end else if ($urandom_range(9) == 0) begin
      send_req(FN_NONE, BYTE_W'($urandom_range(255)), PART_W'($urandom_range(511)),
               PART_W'($urandom_range(511)));
    end else begin
      send_req(FN_READ, BYTE_W'($urandom_range(255)), PART_W'($urandom_range(511)),
               PART_W'($urandom_range(511)));
    end
  endtask

  // one edge-list text: records with random content, some noise, then end of text and one to three counter reads
  task automatic send_document();
    int n_rec;
    bit open_dest;
    n_rec = $urandom_range(1, 12);
    open_dest = 1'b0;
    for (int k = 0; k < n_rec; k++) begin
      if ($urandom_range(99) < 3) send_text(BYTE_W'($urandom_range(255)));
      if ($urandom_range(99) < 10) send_comment();
      repeat ($urandom_range(2)) send_text(pick_blank());
      send_number();
      repeat ($urandom_range(1, 3)) send_text(pick_white());
      send_number();
      if (k == n_rec - 1 && $urandom_range(3) == 0) begin
        open_dest = 1'b1;
        break;
      end
      repeat ($urandom_range(2)) send_text(pick_blank());
      send_text(pick_end());
      if ($urandom_range(99) < 15) send_query();
    end
    // text cut off inside a source number
    if (!open_dest && $urandom_range(99) < 5) send_number();
    send_req(FN_END, BYTE_W'($urandom_range(255)), PART_W'($urandom_range(511)),
             PART_W'($urandom_range(511)));
    repeat ($urandom_range(1, 3)) send_query();
  endtask

  function automatic void add_row(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] b,
                                  logic [PART_W-1:0] r = '0, logic [PART_W-1:0] c = '0,
                                  bit typed = 1'b0, logic [COUNT_W-1:0] count = '0,
                                  logic err = 1'b0);
    steer_row_t row;
    row.func = f;
    row.text_byte = b;
    row.row = r;
    row.col = c;
    row.typed = typed;
    row.want.count = count;
    row.want.err = err;
    steer_rows.push_back(row);
  endfunction

  // result side: random back-pressure
  always @(posedge clk) begin
    out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 7);
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    elph_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expect_q.size() == 0) begin
        $error("result with no request pending: count_value %0h parse_error %0b",
               out_ch.count_value, out_ch.parse_error);
        fails++;
      end else begin
        want = expect_q.pop_front();
        results_checked++;
        if (out_ch.count_value !== want.count) begin
          $error("count_value: expected %0h, got %0h", want.count, out_ch.count_value);
          fails++;
        end
        if (out_ch.parse_error !== want.err) begin
          $error("parse_error: expected %0b, got %0b", want.err, out_ch.parse_error);
          fails++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    bit drained;
    drained = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FN_TEXT;
    in_ch.text_byte = '0;
    in_ch.row = '0;
    in_ch.col = '0;
    out_ch.ready = 1'b0;

    // directed requests: special cases of the parser and the table
    add_row(FN_READ, 8'h00, 9'd0, 9'd0, 1'b1, 32'd0, 1'b0);       // cleared table
    add_row(FN_READ, 8'hFF, 9'd511, 9'd511, 1'b1, 32'd0, 1'b0);   // beyond the partitions
    add_row(FN_NONE, 8'hFF, 9'd511, 9'd511, 1'b1, 32'd0, 1'b0);   // unused selector
    add_row(FN_TEXT, CH_HASH);                                    // comment line
    add_row(FN_TEXT, 8'h80);
    add_row(FN_TEXT, CH_LF);
    add_row(FN_TEXT, "3");                                        // 321 folds to 1
    add_row(FN_TEXT, "2");
    add_row(FN_TEXT, "1");
    add_row(FN_TEXT, CH_TAB);
    add_row(FN_TEXT, CH_LF);                                      // line end between numbers
    add_row(FN_TEXT, "7");
    add_row(FN_TEXT, CH_CR);
    add_row(FN_END, 8'h00, 9'd0, 9'd0, 1'b1, 32'd0, 1'b0);
    add_row(FN_READ, 8'h00, 9'd1, 9'd7);
    add_row(FN_TEXT, "9");                                        // pair closed by end of text
    add_row(FN_TEXT, CH_SPACE);
    add_row(FN_TEXT, "9");
    add_row(FN_END, 8'h00, 9'd0, 9'd0, 1'b1, 32'd0, 1'b0);
    add_row(FN_READ, 8'h00, 9'd9, 9'd9);
    add_row(FN_TEXT, CH_HASH);                                    // comment right after comment
    add_row(FN_TEXT, CH_LF);
    add_row(FN_TEXT, CH_HASH, 9'd0, 9'd0, 1'b1, 32'd0, 1'b1);
    add_row(FN_TEXT, "1", 9'd0, 9'd0, 1'b1, 32'd0, 1'b1);         // ignored after error
    add_row(FN_END, 8'h00, 9'd0, 9'd0, 1'b1, 32'd0, 1'b1);
    add_row(FN_TEXT, 8'h00, 9'd0, 9'd0, 1'b1, 32'd0, 1'b1);       // NUL where a number starts
    add_row(FN_END, 8'hFF, 9'd511, 9'd511, 1'b1, 32'd0, 1'b1);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (steer_rows[i]) begin
      send_req(steer_rows[i].func, steer_rows[i].text_byte, steer_rows[i].row,
               steer_rows[i].col, steer_rows[i].typed, steer_rows[i].want);
    end

    // random edge-list texts
    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) begin
      quiet = (useful_items >= 1000 && useful_items < 1400);
      if (!drained && useful_items >= 700) begin
        // hold requests until the result queue is empty
        drained = 1'b1;
        in_ch.valid <= 1'b0;
        while (expect_q.size() != 0) @(posedge clk);
      end
      send_document();
    end
    quiet = 1'b0;
    in_ch.valid <= 1'b0;

    while (expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("testbench: %0d requests sent, %0d results checked in %0d cycles",
             req_total, results_checked, cycle_count);
    $display("testbench: %0d pairs counted, %0d texts ended with a parse error",
             pairs_counted, error_texts);
    if (fails == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
src/elph_pkg.sv
src/elph_in_if.sv
src/elph_out_if.sv
src/elph_ram.sv
src/elph_parse.sv
src/elph_table.sv
src/edge_list_partition_histogram_top.sv
tb/sv/testbench.sv
